>>> rtl/afs_pkg.sv
package afs_pkg;

  // Dimension width of the source and result fields.
  localparam int DIM_BITS      = 16;
  localparam int BOX_BITS      = 15;
  localparam int MODE_BITS     = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = BOX_BITS;

  // A signed dimension times a zero-extended box size.
  localparam int PROD_BITS = DIM_BITS + BOX_BITS + 1;
  // Magnitude of such a product.
  localparam int MAG_BITS  = DIM_BITS + BOX_BITS;
  // Signed width that holds a source dimension or a (mirrored) box size.
  localparam int FIX_BITS  = ((DIM_BITS > BOX_BITS) ? DIM_BITS : BOX_BITS) + 1;
  // Quotient bits kept by the divider; larger quotients are saturated.
  localparam int QUO_BITS  = DIM_BITS;

  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  // Accepting edge to the edge at which the result transaction completes.
  localparam int LATENCY = QUO_BITS + 4;

  localparam logic [MODE_BITS-1:0] MODE_RAW          = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_BOX          = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_WIDTH        = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_HEIGHT       = 4'd3;
  localparam logic [MODE_BITS-1:0] MODE_INNER        = 4'd4;
  localparam logic [MODE_BITS-1:0] MODE_OUTER        = 4'd5;
  localparam logic [MODE_BITS-1:0] MODE_WIDTH_LIMIT  = 4'd6;
  localparam logic [MODE_BITS-1:0] MODE_HEIGHT_LIMIT = 4'd7;
  localparam logic [MODE_BITS-1:0] MODE_LIMIT        = 4'd8;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HEIGHT = 2'd2;

  localparam logic [MODE_BITS-1:0] FIT_MODE_RESET   = MODE_RAW;
  localparam logic [BOX_BITS-1:0]  BOX_WIDTH_RESET  = 15'd1920;
  localparam logic [BOX_BITS-1:0]  BOX_HEIGHT_RESET = 15'd1080;

  typedef struct packed {
    logic [MODE_BITS-1:0] fit_mode;
    logic [BOX_BITS-1:0]  box_width;
    logic [BOX_BITS-1:0]  box_height;
  } cfg_t;

  // A classified item: what the back end has to do with it.
  typedef struct packed {
    logic                       zdiv;      // divisor was zero, result is zero
    logic                       need_div;  // one dimension is a quotient
    logic                       div_slot;  // 1: height is the quotient
    logic                       q_neg;     // quotient is negative
    logic                       ovf;       // quotient needs more than QUO_BITS
    logic [MAG_BITS-1:0]        num_mag;
    logic [DIM_BITS-1:0]        den_mag;
    logic signed [FIX_BITS-1:0] fix_x;     // width when it is not divided
    logic signed [FIX_BITS-1:0] fix_y;     // height when it is not divided
  } job_t;

endpackage

>>> rtl/afs_front.sv
module afs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [afs_pkg::DIM_BITS-1:0]  in_src_width,
  input  logic signed [afs_pkg::DIM_BITS-1:0]  in_src_height,
  input  afs_pkg::cfg_t                        cfg,
  input  logic [afs_pkg::FIFO_CNT_BITS-1:0]    fifo_level,
  output logic                                 busy,
  output logic                                 push,
  output afs_pkg::job_t                        push_job
);

  localparam int DimBits  = afs_pkg::DIM_BITS;
  localparam int ProdBits = afs_pkg::PROD_BITS;
  localparam int MagBits  = afs_pkg::MAG_BITS;
  localparam int FixBits  = afs_pkg::FIX_BITS;

  logic                       accept;
  logic [afs_pkg::FIFO_CNT_BITS:0] credit_sum;

  // Stage 1: the two cross products.
  logic                       s1_valid_r;
  logic signed [DimBits-1:0]  s1_sx_r, s1_sy_r;
  logic signed [ProdBits-1:0] s1_px_r, s1_py_r;
  logic signed [ProdBits-1:0] px_nxt, py_nxt;

  // Stage 2: classified item.
  logic                       s2_valid_r;
  afs_pkg::job_t              s2_job_r;
  afs_pkg::job_t              job_nxt;

  // Every item in flight in the front end is counted against the queue,
  // so a push always finds room.
  assign credit_sum = {1'b0, fifo_level} + (afs_pkg::FIFO_CNT_BITS + 1)'(s1_valid_r)
                    + (afs_pkg::FIFO_CNT_BITS + 1)'(s2_valid_r);
  assign busy   = credit_sum >= (afs_pkg::FIFO_CNT_BITS + 1)'(afs_pkg::FIFO_DEPTH);
  assign accept = start && !busy;

  assign px_nxt = in_src_width  * $signed({1'b0, cfg.box_height});
  assign py_nxt = in_src_height * $signed({1'b0, cfg.box_width});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sx_r <= in_src_width;
      s1_sy_r <= in_src_height;
      s1_px_r <= px_nxt;
      s1_py_r <= py_nxt;
    end
    if (s1_valid_r) begin
      s2_job_r <= job_nxt;
    end
  end

  always_comb begin
    logic signed [FixBits-1:0]  sx, sy, bx, by, mx, my;
    logic [MagBits-1:0]         lhs, rhs;
    logic signed [ProdBits-1:0] num;
    logic signed [DimBits-1:0]  den;
    logic                       cut_w, cut_h, wide, use_div, slot;

    sx  = FixBits'(s1_sx_r);
    sy  = FixBits'(s1_sy_r);
    bx  = $signed(FixBits'(cfg.box_width));
    by  = $signed(FixBits'(cfg.box_height));
    mx  = s1_sx_r[DimBits-1] ? -bx : bx;
    my  = s1_sy_r[DimBits-1] ? -by : by;
    // |sx|*by and |sy|*bx are the magnitudes of the stored products.
    lhs = s1_px_r[ProdBits-1] ? MagBits'(-s1_px_r) : MagBits'(s1_px_r);
    rhs = s1_py_r[ProdBits-1] ? MagBits'(-s1_py_r) : MagBits'(s1_py_r);
    cut_w = sx >= bx;
    cut_h = sy >= by;
    wide  = 1'b0;

    job_nxt.fix_x = sx;
    job_nxt.fix_y = sy;
    use_div = 1'b0;
    slot    = 1'b0;
    num     = s1_px_r;
    den     = s1_sy_r;

    unique case (cfg.fit_mode) inside
      afs_pkg::MODE_RAW: ;
      afs_pkg::MODE_BOX: begin
        job_nxt.fix_x = bx;
        job_nxt.fix_y = by;
      end
      afs_pkg::MODE_WIDTH: begin
        job_nxt.fix_x = bx;
        use_div = 1'b1;
        slot    = 1'b1;
        num     = s1_py_r;
        den     = s1_sx_r;
      end
      afs_pkg::MODE_HEIGHT: begin
        job_nxt.fix_y = by;
        use_div = 1'b1;
        num     = s1_px_r;
        den     = s1_sy_r;
      end
      afs_pkg::MODE_INNER, afs_pkg::MODE_OUTER: begin
        wide = (cfg.fit_mode == afs_pkg::MODE_INNER) ? (lhs > rhs) : (lhs < rhs);
        use_div = 1'b1;
        if (wide) begin
          // Mirrored box width times the height over the width.
          job_nxt.fix_x = mx;
          slot = 1'b1;
          num  = s1_sx_r[DimBits-1] ? -s1_py_r : s1_py_r;
          den  = s1_sx_r;
        end else begin
          job_nxt.fix_y = my;
          num  = s1_sy_r[DimBits-1] ? -s1_px_r : s1_px_r;
          den  = s1_sy_r;
        end
      end
      afs_pkg::MODE_WIDTH_LIMIT: begin
        if (cut_w) begin
          job_nxt.fix_x = bx;
          use_div = 1'b1;
          slot    = 1'b1;
          num     = s1_py_r;
          den     = s1_sx_r;
        end
      end
      afs_pkg::MODE_HEIGHT_LIMIT: begin
        if (cut_h) begin
          job_nxt.fix_y = by;
          use_div = 1'b1;
          num     = s1_px_r;
          den     = s1_sy_r;
        end
      end
      afs_pkg::MODE_LIMIT: begin
        if (s1_sx_r > s1_sy_r) begin
          if (cut_w) begin
            job_nxt.fix_x = bx;
            use_div = 1'b1;
            slot    = 1'b1;
            num     = s1_py_r;
            den     = s1_sx_r;
          end
        end else if (cut_h) begin
          job_nxt.fix_y = by;
          use_div = 1'b1;
          num     = s1_px_r;
          den     = s1_sy_r;
        end
      end
      default: ;
    endcase

    job_nxt.zdiv     = use_div && (den == '0);
    job_nxt.need_div = use_div && (den != '0);
    job_nxt.div_slot = slot;
    job_nxt.q_neg    = num[ProdBits-1] ^ den[DimBits-1];
    job_nxt.num_mag  = num[ProdBits-1] ? MagBits'(-num) : MagBits'(num);
    // The most negative divisor maps onto its own pattern, which read
    // unsigned is the right magnitude.
    job_nxt.den_mag  = den[DimBits-1] ? DimBits'(-den) : DimBits'(den);
    job_nxt.ovf      = (job_nxt.num_mag >> DimBits) >= MagBits'(job_nxt.den_mag);
    if (job_nxt.zdiv) begin
      job_nxt.fix_x = '0;
      job_nxt.fix_y = '0;
    end
  end

  assign push     = s2_valid_r;
  assign push_job = s2_job_r;

endmodule

>>> rtl/afs_queue.sv
module afs_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  afs_pkg::job_t                     push_job,
  output logic                              head_valid,
  output afs_pkg::job_t                     head_job,
  output logic [afs_pkg::FIFO_CNT_BITS-1:0] level
);

  afs_pkg::job_t                       mem_r [afs_pkg::FIFO_DEPTH];
  logic [afs_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [afs_pkg::FIFO_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                                pop;

  // The back end takes the head in every cycle that it is present.
  assign head_valid = cnt_r != '0;
  assign pop        = head_valid;
  assign head_job   = mem_r[rd_ptr_r];
  assign level      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/afs_back.sv
module afs_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                head_valid,
  input  afs_pkg::job_t                       head_job,
  output logic                                out_strobe,
  output logic signed [afs_pkg::DIM_BITS-1:0] out_width,
  output logic signed [afs_pkg::DIM_BITS-1:0] out_height,
  output logic                                out_zero_divisor,
  output logic                                out_clipped
);

  localparam int DimBits = afs_pkg::DIM_BITS;
  localparam int FixBits = afs_pkg::FIX_BITS;
  localparam int MagBits = afs_pkg::MAG_BITS;
  localparam int QuoBits = afs_pkg::QUO_BITS;

  localparam logic [DimBits-1:0] DimMaxBits = {1'b0, {(DimBits-1){1'b1}}};
  localparam logic [DimBits-1:0] DimMinBits = {1'b1, {(DimBits-1){1'b0}}};
  localparam logic signed [FixBits-1:0] FixDimMax =
    $signed({{(FixBits-DimBits){1'b0}}, DimMaxBits});
  localparam logic signed [FixBits-1:0] FixDimMin =
    $signed({{(FixBits-DimBits){1'b1}}, DimMinBits});

  // Restoring divider, one quotient bit per stage, most significant first.
  logic                st_valid_r [QuoBits];
  afs_pkg::job_t       st_job_r   [QuoBits];
  logic [QuoBits-1:0]  st_quo_r   [QuoBits];
  logic                stin_valid [QuoBits];
  afs_pkg::job_t       stin_job   [QuoBits];
  logic [QuoBits-1:0]  stin_quo   [QuoBits];

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int BitIdx = QuoBits - 1 - k;
    logic          ge;
    afs_pkg::job_t job_nxt;
    logic [QuoBits-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign stin_valid[k] = head_valid;
      assign stin_job[k]   = head_job;
      assign stin_quo[k]   = '0;
    end else begin : g_chain
      assign stin_valid[k] = st_valid_r[k-1];
      assign stin_job[k]   = st_job_r[k-1];
      assign stin_quo[k]   = st_quo_r[k-1];
    end

    always_comb begin
      ge      = (stin_job[k].num_mag >> BitIdx) >= MagBits'(stin_job[k].den_mag);
      job_nxt = stin_job[k];
      quo_nxt = stin_quo[k];
      quo_nxt[BitIdx] = ge;
      if (ge) begin
        job_nxt.num_mag = stin_job[k].num_mag - (MagBits'(stin_job[k].den_mag) << BitIdx);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[k] <= 1'b0;
      end else begin
        st_valid_r[k] <= stin_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      st_job_r[k] <= job_nxt;
      st_quo_r[k] <= quo_nxt;
    end
  end

  function automatic logic [DimBits:0] clamp_fix(input logic signed [FixBits-1:0] v);
    logic [DimBits:0] res;
    if (v > FixDimMax) begin
      res = {1'b1, DimMaxBits};
    end else if (v < FixDimMin) begin
      res = {1'b1, DimMinBits};
    end else begin
      res = {1'b0, v[DimBits-1:0]};
    end
    return res;
  endfunction

  afs_pkg::job_t       fin_job;
  logic [QuoBits-1:0]  fin_quo;
  logic [DimBits:0]    quo_res, fx_res, fy_res;
  logic [DimBits-1:0]  w_nxt, h_nxt;
  logic                clip_nxt;

  logic                out_strobe_r;
  logic [DimBits-1:0]  out_width_r, out_height_r;
  logic                out_zdiv_r, out_clip_r;

  assign fin_job = st_job_r[QuoBits-1];
  assign fin_quo = st_quo_r[QuoBits-1];

  always_comb begin
    // Saturated, signed quotient; truncation toward zero is done on the
    // magnitude before the sign is applied.
    if (fin_job.ovf) begin
      quo_res = {1'b1, (fin_job.q_neg ? DimMinBits : DimMaxBits)};
    end else if (!fin_job.q_neg) begin
      quo_res = (fin_quo > DimMaxBits) ? {1'b1, DimMaxBits} : {1'b0, fin_quo};
    end else begin
      quo_res = (fin_quo > DimMinBits) ? {1'b1, DimMinBits} : {1'b0, DimBits'(-fin_quo)};
    end
    fx_res = clamp_fix(fin_job.fix_x);
    fy_res = clamp_fix(fin_job.fix_y);
    if (fin_job.need_div && !fin_job.div_slot) begin
      fx_res = quo_res;
    end
    if (fin_job.need_div && fin_job.div_slot) begin
      fy_res = quo_res;
    end
    w_nxt    = fx_res[DimBits-1:0];
    h_nxt    = fy_res[DimBits-1:0];
    clip_nxt = (fx_res[DimBits] || fy_res[DimBits]) && !fin_job.zdiv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= st_valid_r[QuoBits-1];
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid_r[QuoBits-1]) begin
      out_width_r  <= w_nxt;
      out_height_r <= h_nxt;
      out_zdiv_r   <= fin_job.zdiv;
      out_clip_r   <= clip_nxt;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_width        = $signed(out_width_r);
  assign out_height       = $signed(out_height_r);
  assign out_zero_divisor = out_zdiv_r;
  assign out_clipped      = out_clip_r;

endmodule

>>> rtl/aspect_fit_scaler_top.sv
// An accepted transaction passes the front-end stages, the queue, the divider
// stages and the output register before it drives out_strobe.
// Throughput: one transaction per cycle, set by the divider, which is pipelined
// with one quotient bit per stage. The receiver cannot stall, so busy stays low.
// Reset: synchronous, active low; clears all valid flags and the queue and
// loads the fit mode (raw) and the box size (1920 x 1080).
module aspect_fit_scaler_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input transactions.
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [afs_pkg::DIM_BITS-1:0]      in_src_width,
  input  logic signed [afs_pkg::DIM_BITS-1:0]      in_src_height,
  // Result transactions, one cycle each.
  output logic                                     out_strobe,
  output logic signed [afs_pkg::DIM_BITS-1:0]      out_width,
  output logic signed [afs_pkg::DIM_BITS-1:0]      out_height,
  output logic                                     out_zero_divisor,
  output logic                                     out_clipped,
  // Configuration writes.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [afs_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [afs_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  // The configuration registers. The user must change them only while no transaction
  // is in flight, as the block does not enforce it; the front end reads them directly.
  logic [afs_pkg::MODE_BITS-1:0] fit_mode_r;
  logic [afs_pkg::BOX_BITS-1:0]  box_width_r;
  logic [afs_pkg::BOX_BITS-1:0]  box_height_r;
  afs_pkg::cfg_t                 cfg;

  // Classified items travel from the front end through a short queue to
  // the divider back end.
  logic                              push;
  afs_pkg::job_t                     push_job;
  logic                              head_valid;
  afs_pkg::job_t                     head_job;
  logic [afs_pkg::FIFO_CNT_BITS-1:0] fifo_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= afs_pkg::FIT_MODE_RESET;
      box_width_r  <= afs_pkg::BOX_WIDTH_RESET;
      box_height_r <= afs_pkg::BOX_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        afs_pkg::REG_FIT_MODE:   fit_mode_r   <= cfg_data[afs_pkg::MODE_BITS-1:0];
        afs_pkg::REG_BOX_WIDTH:  box_width_r  <= cfg_data[afs_pkg::BOX_BITS-1:0];
        afs_pkg::REG_BOX_HEIGHT: box_height_r <= cfg_data[afs_pkg::BOX_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.fit_mode   = fit_mode_r;
  assign cfg.box_width  = box_width_r;
  assign cfg.box_height = box_height_r;

  // Front end: forms the two cross products, then picks the fit, the
  // numerator and divisor, and flags zero divisors and quotient overflow.
  afs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_src_width  (in_src_width),
    .in_src_height (in_src_height),
    .cfg           (cfg),
    .fifo_level    (fifo_level),
    .busy          (busy),
    .push          (push),
    .push_job      (push_job)
  );

  afs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (fifo_level)
  );

  // Back end: restoring divider, then saturation and the output register.
  afs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .out_strobe       (out_strobe),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_zero_divisor (out_zero_divisor),
    .out_clipped      (out_clipped)
  );

  // Every accepted transaction produces its result.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(afs_pkg::LATENCY) out_strobe)
    else $error("accepted transaction produced no result");

  // No result appears without an accepted transaction behind it.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, afs_pkg::LATENCY))
    else $error("result without an accepted transaction");

  // A zero divisor yields a zero rectangle and never counts as clipped.
  a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_divisor) |->
      (out_width == '0) && (out_height == '0) && !out_clipped)
    else $error("zero divisor result is not a clean zero");

endmodule
